// ===== design/trid_pkg.sv =====
// ----------------------------------------------------------------------------
// trid_pkg
// Types and constants shared by the TGA run-length image decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trid_pkg;

   // Result kinds, carried on the result channel's tuser.
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_RUN    = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Error codes of an error result.
   typedef enum logic [1:0] {
      ERR_BAD_TYPE  = 2'd0,
      ERR_ZERO_DIM  = 2'd1,
      ERR_BAD_DEPTH = 2'd2,
      ERR_TRUNCATED = 2'd3
   } err_type;

   // Decoder phase, one-hot.
   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_PIXELS = 3'b010,
      PHASE_IDLE   = 3'b100
   } phase_type;

   // Header byte positions.
   localparam logic [4:0] HDR_TYPE_IDX      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO_IDX  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI_IDX  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO_IDX = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI_IDX = 5'd15;
   localparam logic [4:0] HDR_DEPTH_IDX     = 5'd16;
   localparam logic [4:0] HDR_LAST_IDX      = 5'd17;

   // Accepted header values.
   localparam logic [7:0] TYPE_RAW   = 8'd2;
   localparam logic [7:0] TYPE_RLE   = 8'd10;
   localparam logic [7:0] DEPTH_RGB  = 8'd24;
   localparam logic [7:0] DEPTH_RGBA = 8'd32;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic        upside_down;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic        image_done;
      err_type     error_code;
   } result_type;

   // Results produced by one accepted byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

`default_nettype wire

// ===== design/trid_core.sv =====
// ----------------------------------------------------------------------------
// trid_core
// Decoder state and the combinational update for one file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module trid_core
   import trid_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_file,
   output step_type        results
);

   phase_type   phase_ff,         phase_in;
   logic [4:0]  header_index_ff,  header_index_in;
   logic        is_rle_ff,        is_rle_in;
   logic        wide_pixels_ff,   wide_pixels_in;
   logic [15:0] width_ff,         width_in;
   logic [15:0] height_ff,        height_in;
   logic [31:0] pixels_left_ff,   pixels_left_in;
   logic [7:0]  packet_left_ff,   packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] pixel_bytes_ff,   pixel_bytes_in;

   logic        prim_valid;
   result_type  prim;
   result_type  trunc;
   logic [1:0]  last_byte;
   logic [7:0]  run_count;
   logic [7:0]  clip_count;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_depth;

   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      is_rle_in        = is_rle_ff;
      wide_pixels_in   = wide_pixels_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_bytes_in   = pixel_bytes_ff;

      prim_valid = 1'b0;
      prim       = '0;
      trunc      = '0;
      trunc.kind       = KIND_ERROR;
      trunc.error_code = ERR_TRUNCATED;

      last_byte  = wide_pixels_ff ? 2'd3 : 2'd2;
      run_count  = 8'd1;
      clip_count = 8'd1;
      hdr_type   = pixel_bytes_ff[7:0];
      hdr_depth  = pixel_bytes_ff[15:8];

      unique case (phase_ff)
         PHASE_HEADER: begin
            unique case (header_index_ff)
               HDR_TYPE_IDX:      pixel_bytes_in[7:0] = data_byte;
               HDR_WIDTH_LO_IDX:  width_in[7:0]       = data_byte;
               HDR_WIDTH_HI_IDX:  width_in[15:8]      = data_byte;
               HDR_HEIGHT_LO_IDX: height_in[7:0]      = data_byte;
               HDR_HEIGHT_HI_IDX: height_in[15:8]     = data_byte;
               HDR_DEPTH_IDX: begin
                  // Width and height are complete here, so the pixel total
                  // is formed one byte ahead of the header checks.
                  pixel_bytes_in[15:8] = data_byte;
                  pixels_left_in       = {16'd0, width_ff} * {16'd0, height_ff};
               end
               default: ;
            endcase

            if (header_index_ff != HDR_LAST_IDX) begin
               header_index_in = header_index_ff + 5'd1;
            end else begin
               phase_in   = PHASE_IDLE;
               prim_valid = 1'b1;
               prim.kind  = KIND_ERROR;
               if (hdr_type != TYPE_RAW && hdr_type != TYPE_RLE) begin
                  prim.error_code = ERR_BAD_TYPE;
               end else if (width_ff == 16'd0 || height_ff == 16'd0) begin
                  prim.error_code = ERR_ZERO_DIM;
               end else if (hdr_depth != DEPTH_RGB && hdr_depth != DEPTH_RGBA) begin
                  prim.error_code = ERR_BAD_DEPTH;
               end else begin
                  is_rle_in         = (hdr_type == TYPE_RLE);
                  wide_pixels_in    = (hdr_depth == DEPTH_RGBA);
                  packet_left_in    = 8'd0;
                  packet_is_run_in  = 1'b0;
                  byte_in_pixel_in  = 2'd0;
                  pixel_bytes_in    = 24'd0;
                  phase_in          = PHASE_PIXELS;
                  prim.kind         = KIND_HEADER;
                  prim.error_code   = ERR_BAD_TYPE;
                  prim.image_width  = width_ff;
                  prim.image_height = height_ff;
                  prim.has_alpha    = (hdr_depth == DEPTH_RGBA);
                  prim.upside_down  = ~data_byte[5];
               end
            end
         end

         PHASE_PIXELS: begin
            if (is_rle_ff && packet_left_ff == 8'd0) begin
               // Packet header: top bit selects a run, low seven give length - 1.
               packet_is_run_in = data_byte[7];
               packet_left_in   = {1'b0, data_byte[6:0]} + 8'd1;
            end else if (byte_in_pixel_ff < last_byte) begin
               pixel_bytes_in   = pixel_bytes_ff
                                | (24'(data_byte) << {byte_in_pixel_ff, 3'b000});
               byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
            end else begin
               if (is_rle_ff && packet_is_run_ff) begin
                  run_count      = packet_left_ff;
                  packet_left_in = 8'd0;
               end else begin
                  run_count = 8'd1;
                  if (is_rle_ff) begin
                     packet_left_in = packet_left_ff - 8'd1;
                  end
               end
               if (pixels_left_ff < 32'(run_count)) begin
                  clip_count = pixels_left_ff[7:0];
               end else begin
                  clip_count = run_count;
               end
               pixels_left_in = pixels_left_ff - 32'(clip_count);

               prim_valid        = 1'b1;
               prim.kind         = KIND_RUN;
               prim.error_code   = ERR_BAD_TYPE;
               prim.blue         = pixel_bytes_ff[7:0];
               prim.green        = pixel_bytes_ff[15:8];
               prim.red          = wide_pixels_ff ? pixel_bytes_ff[23:16] : data_byte;
               prim.alpha        = wide_pixels_ff ? data_byte : 8'd0;
               prim.repeat_count = clip_count;
               prim.image_done   = (pixels_left_in == 32'd0);
               if (pixels_left_in == 32'd0) begin
                  phase_in = PHASE_IDLE;
               end
               byte_in_pixel_in = 2'd0;
               pixel_bytes_in   = 24'd0;
            end
         end

         PHASE_IDLE: ;

         default: ;
      endcase

      results = '0;
      if (prim_valid) begin
         results.first = prim;
         results.count = 2'd1;
      end

      if (end_of_file) begin
         // A file that ends before its image is complete reports truncation
         // after anything the same byte produced.
         if (phase_in != PHASE_IDLE) begin
            if (prim_valid) begin
               results.second = trunc;
               results.count  = 2'd2;
            end else begin
               results.first = trunc;
               results.count = 2'd1;
            end
         end
         phase_in         = PHASE_HEADER;
         header_index_in  = 5'd0;
         is_rle_in        = 1'b0;
         wide_pixels_in   = 1'b0;
         width_in         = 16'd0;
         height_in        = 16'd0;
         pixels_left_in   = 32'd0;
         packet_left_in   = 8'd0;
         packet_is_run_in = 1'b0;
         byte_in_pixel_in = 2'd0;
         pixel_bytes_in   = 24'd0;
      end

      if (!step) begin
         results.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_HEADER;
         header_index_ff  <= 5'd0;
         is_rle_ff        <= 1'b0;
         wide_pixels_ff   <= 1'b0;
         width_ff         <= 16'd0;
         height_ff        <= 16'd0;
         pixels_left_ff   <= 32'd0;
         packet_left_ff   <= 8'd0;
         packet_is_run_ff <= 1'b0;
         byte_in_pixel_ff <= 2'd0;
         pixel_bytes_ff   <= 24'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         is_rle_ff        <= is_rle_in;
         wide_pixels_ff   <= wide_pixels_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_bytes_ff   <= pixel_bytes_in;
      end
   end

   // The header position never runs past the descriptor byte.
   a_header_index_bounded: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= HDR_LAST_IDX)
      else $error("header position past the last header byte");

   // While pixels are expected, some pixels must still be missing.
   a_pixels_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_PIXELS |-> pixels_left_ff != 32'd0)
      else $error("pixel phase with no pixels left");

   // A three-byte pixel never collects a fourth byte.
   a_pixel_byte_bounded: assert property (@(posedge clock) disable iff (reset)
      !wide_pixels_ff |-> byte_in_pixel_ff != 2'd3)
      else $error("pixel byte count too high for 24-bit pixels");

endmodule

`default_nettype wire

// ===== design/trid_result_queue.sv =====
// ----------------------------------------------------------------------------
// trid_result_queue
// Small result queue: takes up to two results per cycle, delivers one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module trid_result_queue
   import trid_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  step_type  push,
   output logic      has_room,
   output logic      out_valid,
   input  wire logic out_ready,
   output result_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   assign out_valid   = (count_ff != '0);
   assign out_item    = mem_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   // Room for the largest burst one byte can cause.
   assign has_room    = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_ptr_next);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue fill above its depth");

   a_pair_fits: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> count_ff <= CNT_W'(DEPTH - 2))
      else $error("result pair pushed without room for both");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("result queue fill did not drop after a delivery");

endmodule

`default_nettype wire

// ===== design/tga_rle_image_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_image_decoder
// Output: each result is registered in the result queue (one register stage)
// and offered on rsp_tvalid behind any results already queued.
// Throughput: one byte per cycle while the queue has room for two results.
// A byte that yields two results (a header or a run that leaves pixels missing,
// on the file's last byte) is absorbed by the queue when the output keeps up.
// Reset: synchronous and active high; the decoder returns to the header
// phase and the result queue empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

// The decoder reads a truecolor TGA file one byte per item. The 18-byte
// header is checked for a raw or run-length image type, a 24- or 32-bit
// depth and nonzero dimensions. Pixels follow directly after the header and
// are delivered as RGB(A) runs with a repeat count that is clipped so the
// total never passes width times height. An end of file that arrives before
// the image is complete, with no error reported, adds a truncation error
// after any other result of that byte. Bytes after a completed image or an
// error are ignored until the end of the file.
//
// All decoding for a byte is done by combinational logic from the decoder
// state into the result queue. The input is ready whenever the
// queue has room for two results, so with a default depth of four and an
// output side that takes one result per cycle, the block keeps pace with a
// byte per cycle. RESULT_DEPTH must be at least 3 for that rate.
module tga_rle_image_decoder
   import trid_pkg::*;
#(
   parameter int RESULT_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_file

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] image_width, [31:16] image_height, [32] has_alpha,
   // [33] upside_down, [41:34] red, [49:42] green, [57:50] blue,
   // [65:58] alpha, [73:66] repeat_count, [75:74] error_code, [79:76] zero
   output logic [79:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // image_done
);

   logic       accept;
   logic       queue_room;
   step_type   step_results;
   result_type head;

   // A byte is taken only when the queue can hold everything it may cause.
   assign req_tready = queue_room;
   assign accept     = req_tvalid && req_tready;

   trid_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .results     (step_results)
   );

   trid_result_queue #(
      .DEPTH (RESULT_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_results),
      .has_room  (queue_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {4'd0,
                       head.error_code,
                       head.repeat_count,
                       head.alpha,
                       head.blue,
                       head.green,
                       head.red,
                       head.upside_down,
                       head.has_alpha,
                       head.image_height,
                       head.image_width};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.image_done;

endmodule

`default_nettype wire
